[design/mrect_pkg.sv]
// Shared types and constants for the maximal rectangle of ones core.
// No dependencies; every other file of the block uses this package.
package mrect_pkg;

  localparam int MAX_COLS_DEF = 256;
  localparam int MAX_ROWS_DEF = 1024;

  localparam int ROW_WIDTH_W = 9;
  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = 9'd256;

  localparam int AREA_W = 19;
  localparam logic [AREA_W-1:0] AREA_MAX = '1;

  localparam int IN_TDATA_W = 8;
  localparam int OUT_TDATA_W = 24;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic cell_bit;
    logic last_cell;
    logic row_end;
  } cell_flags_t;

endpackage

[design/maximal_rectangle_of_ones_core.sv]
// Largest all-ones rectangle of a binary matrix streamed one cell per transfer.
// Each cell passes the scoring engine states idle (height memory read), height
// update and check; each stack pop adds a pop-load step (one stack memory read),
// and a row end adds a flush pass. The result is registered once the last cell's row is flushed and the output is free.
// After reset and after every matrix the height memory is swept; cells keep
// entering the 4-entry queue meanwhile. Reset: rst_n, sync.
module maximal_rectangle_of_ones_core #(
  parameter int MAX_COLS = mrect_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = mrect_pkg::MAX_ROWS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [mrect_pkg::ROW_WIDTH_W-1:0]    cfg_wdata,   // row_width
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [mrect_pkg::IN_TDATA_W-1:0]     in_tdata,    // [0] cell_bit
  input  logic                                 in_tlast,    // last_cell
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [mrect_pkg::OUT_TDATA_W-1:0]    out_tdata    // [18:0] largest_area
);
  import mrect_pkg::*;

  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int FLAG_W = $bits(cell_flags_t);
  localparam int QW     = COL_W + FLAG_W;

  logic                  fq_valid;
  logic                  fq_ready;
  logic [COL_W-1:0]      fq_pos;
  cell_flags_t           fq_flags;
  logic                  bq_valid;
  logic                  bq_ready;
  logic [QW-1:0]         bq_data;
  logic                  res_valid;
  logic [AREA_W-1:0]     res_area;

  mrect_front #(
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .cell_bit  (in_tdata[0]),
    .last_cell (in_tlast),
    .q_valid   (fq_valid),
    .q_ready   (fq_ready),
    .q_pos     (fq_pos),
    .q_flags   (fq_flags)
  );

  mrect_fifo #(
    .DATA_W (QW),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  ({fq_pos, fq_flags}),
    .rd_valid (bq_valid),
    .rd_ready (bq_ready),
    .rd_data  (bq_data)
  );

  mrect_back #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (bq_valid),
    .q_ready   (bq_ready),
    .q_pos     (bq_data[QW-1:FLAG_W]),
    .q_flags   (cell_flags_t'(bq_data[FLAG_W-1:0])),
    .out_valid (res_valid),
    .out_ready (out_tready),
    .out_area  (res_area)
  );

  assign out_tvalid = res_valid;
  assign out_tdata  = {{(OUT_TDATA_W - AREA_W){1'b0}}, res_area};

endmodule

[design/mrect_front.sv]
// Input side: holds the row width register and the column counter, and tags
// every accepted cell with its column and a row end flag. Uses mrect_pkg.
module mrect_front #(
  parameter int MAX_COLS = mrect_pkg::MAX_COLS_DEF,
  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [mrect_pkg::ROW_WIDTH_W-1:0]   cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                cell_bit,
  input  logic                                last_cell,
  output logic                                q_valid,
  input  logic                                q_ready,
  output logic [COL_W-1:0]                    q_pos,
  output mrect_pkg::cell_flags_t              q_flags
);
  import mrect_pkg::*;

  localparam int CNT_W = $clog2(MAX_COLS + 1);
  localparam int CMP_W = (CNT_W > ROW_WIDTH_W) ? CNT_W : ROW_WIDTH_W;

  logic [ROW_WIDTH_W-1:0] row_width_r;
  logic [COL_W-1:0]       pos_r;
  logic [COL_W-1:0]       pos_nxt;
  logic [CMP_W-1:0]       width_raw;
  logic [CMP_W-1:0]       width_eff;
  logic [CMP_W-1:0]       pos_inc;
  logic                   row_end;
  logic                   accept;

  always_comb begin
    width_raw = CMP_W'(row_width_r);
    priority if (width_raw == '0) begin
      width_eff = CMP_W'(1);
    end else if (width_raw > CMP_W'(MAX_COLS)) begin
      width_eff = CMP_W'(MAX_COLS);
    end else begin
      width_eff = width_raw;
    end
    pos_inc = CMP_W'(pos_r) + CMP_W'(1);
    row_end = (pos_inc >= width_eff) || last_cell;
    pos_nxt = row_end ? '0 : pos_inc[COL_W-1:0];
  end

  assign in_ready = q_ready;
  assign q_valid  = in_valid;
  assign accept   = in_valid & q_ready;
  assign q_pos    = pos_r;
  assign q_flags  = '{cell_bit: cell_bit, last_cell: last_cell, row_end: row_end};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= ROW_WIDTH_RST;
      pos_r       <= '0;
    end else begin
      if (cfg_we) begin
        row_width_r <= cfg_wdata;
      end
      if (accept) begin
        pos_r <= pos_nxt;
      end
    end
  end

endmodule

[design/mrect_fifo.sv]
// Short register queue between the input side and the scoring engine.
// Uses mrect_pkg for its default depth.
module mrect_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = mrect_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  logic [DATA_W-1:0] wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output logic [DATA_W-1:0] rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              do_wr;
  logic              do_rd;

  assign wr_ready = (count_r != CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_valid & wr_ready;
  assign do_rd    = rd_valid & rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      unique case ({do_wr, do_rd})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[design/mrect_back.sv]
// Scoring engine: column height memory, monotonic stack with cached top
// entries, area multiplier and result register. Uses mrect_pkg.
module mrect_back #(
  parameter int MAX_COLS = mrect_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = mrect_pkg::MAX_ROWS_DEF,
  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  output logic                            q_ready,
  input  logic [COL_W-1:0]                q_pos,
  input  mrect_pkg::cell_flags_t          q_flags,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mrect_pkg::AREA_W-1:0]    out_area
);
  import mrect_pkg::*;

  localparam int CNT_W  = $clog2(MAX_COLS + 1);
  localparam int HT_W   = $clog2(MAX_ROWS + 1);
  localparam int PROD_W = (CNT_W + HT_W > AREA_W) ? CNT_W + HT_W : AREA_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HUPD,
    S_CHECK,
    S_POPLD
  } state_t;

  typedef struct packed {
    logic [COL_W-1:0] idx;
    logic [HT_W-1:0]  ht;
  } entry_t;

  logic [HT_W-1:0] hmem [MAX_COLS];
  entry_t          smem [MAX_COLS];

  state_t            state_r;
  logic [COL_W-1:0]  clr_r;
  logic [COL_W-1:0]  pos_r;
  cell_flags_t       flags_r;
  logic              flush_r;
  logic [HT_W-1:0]   h_r;
  logic [HT_W-1:0]   hrd_r;
  logic [CNT_W-1:0]  depth_r;
  logic [CNT_W-1:0]  bound_r;
  entry_t            top_r;
  entry_t            sec_r;
  entry_t            srd_r;
  logic [PROD_W-1:0] area_r;
  logic [AREA_W-1:0] best_r;
  logic              out_valid_r;
  logic [AREA_W-1:0] out_area_r;

  logic [HT_W-1:0]   h_new;
  logic              pop_go;
  logic              pop_en;
  logic              emit_ok;
  logic              emit;
  logic [CNT_W-1:0]  left;
  logic [CNT_W-1:0]  pop_w;
  logic [CNT_W-1:0]  dm1;
  logic [CNT_W-1:0]  dm3;
  logic [AREA_W-1:0] area_sat;
  logic              h_we;
  logic [COL_W-1:0]  h_waddr;
  logic [HT_W-1:0]   h_wdata;
  logic              h_re;
  logic              s_we;

  always_comb begin
    if (!flags_r.cell_bit) begin
      h_new = '0;
    end else if (hrd_r >= HT_W'(MAX_ROWS)) begin
      h_new = HT_W'(MAX_ROWS);
    end else begin
      h_new = hrd_r + HT_W'(1);
    end

    left = CNT_W'(sec_r.idx);
    if (depth_r > CNT_W'(1)) begin
      pop_w = (bound_r > left) ? bound_r - left - CNT_W'(1) : '0;
    end else begin
      pop_w = bound_r;
    end

    area_sat = (area_r > PROD_W'(AREA_MAX)) ? AREA_MAX : area_r[AREA_W-1:0];
  end

  assign pop_go  = (depth_r != '0) && (flush_r || (top_r.ht >= h_r));
  assign pop_en  = (state_r == S_CHECK) && pop_go;
  assign emit_ok = !out_valid_r || out_ready;
  assign emit    = (state_r == S_CHECK) && !pop_go && flush_r && flags_r.last_cell && emit_ok;
  assign q_ready = (state_r == S_IDLE);
  assign dm1     = depth_r - CNT_W'(1);
  assign dm3     = depth_r - CNT_W'(3);

  assign h_we    = (state_r == S_CLEAR) || (state_r == S_HUPD);
  assign h_waddr = (state_r == S_CLEAR) ? clr_r : pos_r;
  assign h_wdata = (state_r == S_CLEAR) ? '0 : h_new;
  assign h_re    = q_valid && (state_r == S_IDLE);
  assign s_we    = (state_r == S_CHECK) && !pop_go && !flush_r && (depth_r != '0);

  always_ff @(posedge clk) begin
    if (h_we) begin
      hmem[h_waddr] <= h_wdata;
    end
    if (h_re) begin
      hrd_r <= hmem[q_pos];
    end
    if (s_we) begin
      smem[dm1[COL_W-1:0]] <= top_r;
    end
    if (pop_en) begin
      srd_r <= smem[dm3[COL_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      depth_r     <= '0;
      best_r      <= '0;
      flush_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !emit) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          if (clr_r == COL_W'(MAX_COLS - 1)) begin
            clr_r   <= '0;
            state_r <= S_IDLE;
          end else begin
            clr_r <= clr_r + COL_W'(1);
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            pos_r   <= q_pos;
            flags_r <= q_flags;
            flush_r <= 1'b0;
            state_r <= S_HUPD;
          end
        end
        S_HUPD: begin
          h_r     <= h_new;
          bound_r <= CNT_W'(pos_r);
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          if (pop_go) begin
            area_r  <= PROD_W'(pop_w) * PROD_W'(top_r.ht);
            top_r   <= sec_r;
            depth_r <= dm1;
            state_r <= S_POPLD;
          end else if (!flush_r) begin
            sec_r   <= top_r;
            top_r   <= '{idx: pos_r, ht: h_r};
            depth_r <= depth_r + CNT_W'(1);
            if (flags_r.row_end) begin
              flush_r <= 1'b1;
              bound_r <= CNT_W'(pos_r) + CNT_W'(1);
            end else begin
              state_r <= S_IDLE;
            end
          end else if (flags_r.last_cell) begin
            if (emit_ok) begin
              out_valid_r <= 1'b1;
              out_area_r  <= best_r;
              best_r      <= '0;
              state_r     <= S_CLEAR;
            end
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_POPLD: begin
          sec_r <= srd_r;
          if (area_sat > best_r) begin
            best_r <= area_sat;
          end
          state_r <= S_CHECK;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_area  = out_area_r;

endmodule

[tb/sv/tb_maximal_rectangle_of_ones_core.sv]
// Testbench for maximal_rectangle_of_ones_core: streams binary matrices cell by cell and
// checks each largest-area result against a scoreboard that recomputes it with a column
// stack. Depends on mrect_pkg and the core module only.
module tb_maximal_rectangle_of_ones_core;
  timeunit 1ns;
  timeprecision 1ps;

  import mrect_pkg::*;

  localparam int MAX_COLS = MAX_COLS_DEF;
  localparam int MAX_ROWS = MAX_ROWS_DEF;
  localparam int SETTLE_CYCLES = 3000;
  localparam int HOLD_CYCLES = 2500;
  localparam int RANDOM_CELLS = 1650;

  class rect_scoreboard;
    bit [ROW_WIDTH_W-1:0] row_width;
    bit [10:0]            col_height [MAX_COLS];
    bit [8:0]             col_stack [MAX_COLS+1];
    bit [8:0]             depth;
    bit [7:0]             column;
    bit [AREA_W-1:0]      best;
    bit [AREA_W-1:0]      expected_areas [$];
    int unsigned          errors;

    function new();
      row_width = ROW_WIDTH_RST;
      errors = 0;
      clear_matrix();
    endfunction

    function void clear_matrix();
      foreach (col_height[i]) col_height[i] = '0;
      foreach (col_stack[i]) col_stack[i] = '0;
      depth = '0;
      column = '0;
      best = '0;
    endfunction

    function void score(longint unsigned area);
      if (area > AREA_MAX) area = AREA_MAX;
      if (area > best) best = area[AREA_W-1:0];
    endfunction

    // Pops every column at least as tall as floor_h; right_col bounds the rectangles.
    function void pop_down(int unsigned floor_h, int unsigned right_col);
      int unsigned top, ht, left, span;
      while (depth > 0) begin
        top = col_stack[depth-1] % MAX_COLS;
        ht = col_height[top];
        if (ht < floor_h) break;
        depth--;
        if (depth > 0) begin
          left = col_stack[depth-1];
          span = (right_col > left) ? right_col - left - 1 : 0;
        end else begin
          span = right_col;
        end
        score(longint'(span) * longint'(ht));
      end
    endfunction

    function void note_cell(bit cell_bit, bit last_cell);
      int unsigned w, pos, h;
      bit row_end;
      w = row_width;
      if (w < 1) w = 1;
      if (w > MAX_COLS) w = MAX_COLS;
      pos = column;
      h = col_height[pos];
      if (cell_bit) h = (h >= MAX_ROWS) ? MAX_ROWS : h + 1;
      else h = 0;
      col_height[pos] = 11'(h);
      pop_down(h, pos);
      if (depth < MAX_COLS + 1) begin
        col_stack[depth] = 9'(pos);
        depth++;
      end
      row_end = (pos + 1 >= w) || last_cell;
      if (row_end) begin
        pop_down(0, pos + 1);
        depth = '0;
        column = '0;
      end else begin
        column = 8'(pos + 1);
      end
      if (last_cell) begin
        expected_areas = {expected_areas, best};
        clear_matrix();
      end
    endfunction

    function void check_area(logic [AREA_W-1:0] got);
      bit [AREA_W-1:0] want;
      if (expected_areas.size() == 0) begin
        $error("largest_area: no result expected, actual %0d", got);
        errors++;
      end else begin
        want = expected_areas.pop_front();
        if (got !== want) begin
          $error("largest_area mismatch: expected %0d, actual %0d", want, got);
          errors++;
        end
      end
    endfunction

    function int unsigned pending();
      return expected_areas.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [ROW_WIDTH_W-1:0] cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [0] cell_bit
  logic                   in_tlast = 1'b0; // last_cell
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [18:0] largest_area

  rect_scoreboard sb;
  int unsigned    burst_left = 0;
  int unsigned    cells_sent = 0;
  bit             hold_req = 1'b0;

  maximal_rectangle_of_ones_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #6 clk = ~clk;

  task automatic push_cell(input bit cell_bit, input bit last_cell);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 20);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_TDATA_W-1){1'b0}}, cell_bit};
    in_tlast <= last_cell;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_cell(cell_bit, last_cell);
    cells_sent++;
  endtask

  task automatic send_cells(input int unsigned count, input int unsigned ones_pct);
    for (int unsigned i = 0; i < count; i++) begin
      push_cell($urandom_range(0, 99) < ones_pct, i == count - 1);
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_width(input bit [ROW_WIDTH_W-1:0] value);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.row_width = value;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_area(out_tdata[AREA_W-1:0]);
  end

  initial begin
    int unsigned run, stall;
    bit hold_done;
    hold_done = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      run = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      out_tready <= 1'b1;
      repeat (run) @(posedge clk);
      stall = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 5);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    #30ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int unsigned sel, w, eff, mats, rows, total, pct, stop_at;
    bit first;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset width, matrix ending inside its first row.
    push_cell(1, 0); push_cell(1, 0); push_cell(0, 0); push_cell(1, 1);
    // Width zero behaves as one column.
    write_width(9'd0);
    push_cell(1, 0); push_cell(1, 1);
    push_cell(0, 1);
    // Width narrowed while the current row is already past it.
    write_width(9'd3);
    push_cell(1, 0); push_cell(1, 0); push_cell(1, 0);
    push_cell(1, 0); push_cell(0, 0); push_cell(1, 0);
    push_cell(1, 0); push_cell(1, 0);
    write_width(9'd2);
    push_cell(1, 0); push_cell(1, 0); push_cell(1, 1);
    // Width above the column count is clamped.
    write_width(9'd511);
    push_cell(1, 0); push_cell(0, 0); push_cell(1, 1);

    stop_at = cells_sent + RANDOM_CELLS;
    // One column of ones taller than the height limit.
    write_width(9'd1);
    send_cells(MAX_ROWS + 6, 100);

    first = 1'b1;
    while (cells_sent < stop_at) begin
      sel = $urandom_range(0, 19);
      if (first) w = $urandom_range(2, 6);
      else if (sel < 13) w = $urandom_range(1, 12);
      else if (sel < 16) w = $urandom_range(13, 40);
      else if (sel == 16) w = 0;
      else if (sel == 17) w = MAX_COLS;
      else if (sel == 18) w = $urandom_range(MAX_COLS + 1, 511);
      else w = MAX_COLS - 1;
      write_width(w[ROW_WIDTH_W-1:0]);
      eff = (w < 1) ? 1 : (w > MAX_COLS) ? MAX_COLS : w;
      if (first) begin
        hold_req = 1'b1;
        mats = 8;
        first = 1'b0;
      end else begin
        mats = (eff > 40) ? 1 : $urandom_range(1, 5);
      end
      repeat (mats) begin
        if (eff > 40) rows = $urandom_range(1, 2);
        else if (eff <= 4) rows = $urandom_range(1, 20);
        else rows = $urandom_range(1, 8);
        total = rows * eff;
        if ($urandom_range(0, 4) == 0) total = $urandom_range(1, total);
        case ($urandom_range(0, 3))
          0: pct = 15;
          1: pct = 50;
          2: pct = 85;
          default: pct = 100;
        endcase
        send_cells(total, pct);
      end
    end

    settle();
    if (sb.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
